// ===== rtl/pulse_frame_temperature_converter_core_defines.svh =====
// Assertion macros shared by the pulse frame temperature converter RTL.
`ifndef PULSE_FRAME_TEMPERATURE_CONVERTER_CORE_DEFINES_SVH
`define PULSE_FRAME_TEMPERATURE_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PFTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

`define PFTC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define PFTC_ASSERT(lbl, clk, rst, prop)

`define PFTC_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== rtl/pftc_pkg.sv =====
// Package: widths, constants and types of the pulse frame temperature converter.
`timescale 1ns / 1ps
package pftc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int IN_W        = 16;
   // only the low bits of the sampled count take part
   localparam int CNT_W       = (COUNT_WIDTH < IN_W) ? COUNT_WIDTH : IN_W;
   localparam int TICK_W      = 8;
   localparam int QUIET_W     = 16;
   localparam int TEMP_W      = 21;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;

   // conversion datapath, signed, wide enough for count*16 and the clamp bounds
   localparam int CALC_W   = (CNT_W + 7 > TEMP_W + 1) ? CNT_W + 7 : TEMP_W + 1;
   localparam int ROUND_SH = 16;
   localparam int PROD_W   = CALC_W + ROUND_SH;
   localparam int COEF_W   = 10;

   localparam int BASE_OFFSET = 12816;
   localparam int LOW_POINT   = 7680;
   localparam int HIGH_POINT  = 25600;
   localparam int LOW_COEF    = 328;
   localparam int HIGH_COEF   = 786;
   localparam int ROUND_HALF  = 2 ** (ROUND_SH - 1);
   localparam int TEMP_MAX    = 2 ** (TEMP_W - 1) - 1;
   localparam int TEMP_MIN    = -(2 ** (TEMP_W - 1));

   localparam int TICK_RST  = 5;
   localparam int QUIET_RST = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_LIMIT = CSR_IDX_W'(1);

   localparam int QUEUE_DEPTH = 2;   // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic      done;
      count_type count;
   } entry_type;

   typedef enum logic [1:0] {
      CORR_NONE,
      CORR_LOW,
      CORR_HIGH
   } corr_type;

   typedef struct packed {
      logic                     done;
      count_type                count;
      logic signed [CALC_W-1:0] base;
      logic [CALC_W-1:0]        gap;
      corr_type                 sel;
   } stage_type;

endpackage

// ===== rtl/pftc_if.sv =====
// Handshake interfaces: sample request, result response and register write.
`timescale 1ns / 1ps
interface pftc_req_if;
   import pftc_pkg::*;
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] pulse_count;
   modport source (output valid, output pulse_count, input ready);
   modport sink (input valid, input pulse_count, output ready);
endinterface

interface pftc_rsp_if;
   import pftc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     frame_done;
   logic signed [TEMP_W-1:0] temperature;
   logic [IN_W-1:0]          frame_count;
   modport source (output valid, output frame_done, output temperature,
                   output frame_count, input ready);
   modport sink (input valid, input frame_done, input temperature,
                 input frame_count, output ready);
endinterface

interface pftc_csr_if;
   import pftc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pulse_frame_temperature_converter_core.sv =====
// Top level of the pulse frame temperature converter.
// Takes one counter sample per clock when the response side keeps up; the
// sample updates the quiet timer in the cycle it is accepted, so the
// single-cycle timer update in the front end sets the rate of one sample per
// clock. Every sample yields one response, which passes through the queue,
// the stage-1 register and the response register; a two-entry queue between
// detection and conversion absorbs short response stalls. frame_done marks a
// finished frame: temperature (1/256 degree, signed) and frame_count are valid
// then and zero otherwise, and the pulse counter should be cleared. Register
// writes are taken in any cycle and should be made only while the block is idle.
`timescale 1ns / 1ps
module pulse_frame_temperature_converter_core (
   input  logic       clock,
   input  logic       reset,
   pftc_req_if.sink   req_bus,
   pftc_rsp_if.source rsp_bus,
   pftc_csr_if.sink   csr_bus
);
   import pftc_pkg::*;

   logic      push_valid;
   entry_type push_data;
   logic      queue_full;
   logic      pop_valid;
   entry_type pop_data;
   logic      pop_ready;

   pftc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   pftc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   pftc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== rtl/pftc_front.sv =====
// Front end: registers, quiet timer and frame end detection per sample.
`timescale 1ns / 1ps
`include "pulse_frame_temperature_converter_core_defines.svh"
module pftc_front (
   input  logic                clock,
   input  logic                reset,
   pftc_req_if.sink            req_bus,
   pftc_csr_if.sink            csr_bus,
   output logic                push_valid,
   output pftc_pkg::entry_type push_data,
   input  logic                queue_full
);
   import pftc_pkg::*;

   logic [TICK_W-1:0]  tick_ms_ff, tick_ms_in;
   logic [QUIET_W-1:0] quiet_limit_ff, quiet_limit_in;
   logic [QUIET_W-1:0] quiet_time_ff, quiet_time_in;
   count_type          last_count_ff, last_count_in;

   logic               accept;
   count_type          count;
   logic [QUIET_W:0]   quiet_sum;
   logic [QUIET_W-1:0] quiet_sat;
   logic               done;

   assign req_bus.ready = !queue_full;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && !queue_full;
   assign count         = req_bus.pulse_count[CNT_W-1:0];

   assign quiet_sum = {1'b0, quiet_time_ff} + (QUIET_W + 1)'(tick_ms_ff);
   assign quiet_sat = quiet_sum[QUIET_W] ? '1 : quiet_sum[QUIET_W-1:0];

   always_comb begin
      quiet_time_in = quiet_time_ff;
      last_count_in = last_count_ff;
      done          = 1'b0;
      if (accept) begin
         if (count == '0) begin
            quiet_time_in = '0;
         end else if (count != last_count_ff) begin
            quiet_time_in = '0;
            last_count_in = count;
         end else begin
            quiet_time_in = quiet_sat;
            if (quiet_sat > quiet_limit_ff) begin
               done          = 1'b1;
               quiet_time_in = '0;
               last_count_in = '0;
            end
         end
      end
   end

   always_comb begin
      tick_ms_in     = tick_ms_ff;
      quiet_limit_in = quiet_limit_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_TICK_MS:     tick_ms_in     = csr_bus.data[TICK_W-1:0];
            CSR_QUIET_LIMIT: quiet_limit_in = csr_bus.data[QUIET_W-1:0];
            default: ;
         endcase
      end
   end

   assign push_valid      = accept;
   assign push_data.done  = done;
   assign push_data.count = count;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff     <= TICK_W'(TICK_RST);
         quiet_limit_ff <= QUIET_W'(QUIET_RST);
         quiet_time_ff  <= '0;
         last_count_ff  <= '0;
      end else begin
         tick_ms_ff     <= tick_ms_in;
         quiet_limit_ff <= quiet_limit_in;
         quiet_time_ff  <= quiet_time_in;
         last_count_ff  <= last_count_in;
      end
   end

   `PFTC_ASSERT(a_done_clears_state, clock, reset, push_valid && push_data.done |=> quiet_time_ff == '0 && last_count_ff == '0)
   `PFTC_ASSERT_NEVER(a_done_on_zero_count, clock, reset, push_valid && push_data.done && push_data.count == '0)

endmodule

// ===== rtl/pftc_queue.sv =====
// Short queue that decouples frame detection from conversion.
`timescale 1ns / 1ps
`include "pulse_frame_temperature_converter_core_defines.svh"
module pftc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  pftc_pkg::entry_type push_data,
   output logic                full,
   output logic                pop_valid,
   output pftc_pkg::entry_type pop_data,
   input  logic                pop_ready
);
   import pftc_pkg::*;

   entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]  level_ff, level_in;
   logic               push;
   logic               pop;

   assign full      = (level_ff == QLVL_W'(QUEUE_DEPTH));
   assign pop_valid = (level_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PFTC_ASSERT_NEVER(a_level_bound, clock, reset, level_ff > QLVL_W'(QUEUE_DEPTH))
   `PFTC_ASSERT(a_ptr_level, clock, reset, 1'b1 |-> QPTR_W'(wr_ptr_ff - rd_ptr_ff) == level_ff[QPTR_W-1:0])

endmodule

// ===== rtl/pftc_back.sv =====
// Back end: two-stage conversion of completed frames and response register.
`timescale 1ns / 1ps
`include "pulse_frame_temperature_converter_core_defines.svh"
module pftc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  pftc_pkg::entry_type pop_data,
   output logic                pop_ready,
   pftc_rsp_if.source          rsp_bus
);
   import pftc_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   stage_type                s1_ff, s1_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     frame_done_ff;
   logic signed [TEMP_W-1:0] temperature_ff;
   logic [IN_W-1:0]          frame_count_ff;

   logic                     out_free;
   logic                     s1_move;
   logic signed [CALC_W-1:0] base;
   logic [COEF_W-1:0]        coef;
   logic [PROD_W-1:0]        prod_rnd;
   logic [CALC_W-1:0]        corr;
   logic signed [CALC_W-1:0] temp_full;
   logic signed [TEMP_W-1:0] temp_sat;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign pop_ready = !s1_valid_ff || out_free;
   assign s1_move   = s1_valid_ff && out_free;

   // stage 1: base value in 1/256 degree and distance from the nearer knee
   assign base = $signed(CALC_W'(pop_data.count) << 4) - $signed(CALC_W'(BASE_OFFSET));

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (pop_ready) begin
         s1_valid_in    = pop_valid;
         s1_in.done     = pop_data.done;
         s1_in.count    = pop_data.count;
         s1_in.base     = base;
         s1_in.gap      = '0;
         s1_in.sel      = CORR_NONE;
         if (base < $signed(CALC_W'(LOW_POINT))) begin
            s1_in.sel = CORR_LOW;
            s1_in.gap = CALC_W'($signed(CALC_W'(LOW_POINT)) - base);
         end else if (base > $signed(CALC_W'(HIGH_POINT))) begin
            s1_in.sel = CORR_HIGH;
            s1_in.gap = CALC_W'(base - $signed(CALC_W'(HIGH_POINT)));
         end
      end
   end

   // stage 2: rounded correction, subtract, clamp
   always_comb begin
      case (s1_ff.sel)
         CORR_LOW:  coef = COEF_W'(LOW_COEF);
         CORR_HIGH: coef = COEF_W'(HIGH_COEF);
         default:   coef = '0;
      endcase
   end

   assign prod_rnd  = PROD_W'(s1_ff.gap) * PROD_W'(coef) + PROD_W'(ROUND_HALF);
   assign corr      = prod_rnd[PROD_W-1:ROUND_SH];
   assign temp_full = s1_ff.base - $signed(corr);

   always_comb begin
      if (temp_full > $signed(CALC_W'(TEMP_MAX))) begin
         temp_sat = TEMP_W'(TEMP_MAX);
      end else if (temp_full < $signed(CALC_W'(TEMP_MIN))) begin
         temp_sat = TEMP_W'(TEMP_MIN);
      end else begin
         temp_sat = temp_full[TEMP_W-1:0];
      end
   end

   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_move) begin
         frame_done_ff  <= s1_ff.done;
         temperature_ff <= s1_ff.done ? temp_sat : '0;
         frame_count_ff <= s1_ff.done ? IN_W'(s1_ff.count) : '0;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.frame_done  = frame_done_ff;
   assign rsp_bus.temperature = temperature_ff;
   assign rsp_bus.frame_count = frame_count_ff;

   `PFTC_ASSERT_NEVER(a_idle_result_zero, clock, reset, rsp_valid_ff && !frame_done_ff && (temperature_ff != '0 || frame_count_ff != '0))
   `PFTC_ASSERT_NEVER(a_done_count_nonzero, clock, reset, rsp_valid_ff && frame_done_ff && frame_count_ff == '0)
   `PFTC_ASSERT(a_stage_holds, clock, reset, s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_ff))

endmodule
